### hdl/bbls_pkg.sv
// Shared types and constants of the 3x3 mean blur and Laplacian sharpening unit.
package bbls_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned WREG_W     = 11;
  localparam int unsigned HREG_W     = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned RING_W     = 11;
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned LINE_W     = 2 * PIX_W;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;

  localparam logic [12:0] MEAN_RECIP = 13'd7282;
  localparam int unsigned MEAN_SHIFT = 16;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    MODE_MEAN    = 1'b0,
    MODE_SHARPEN = 1'b1
  } filt_mode_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             drain;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } out_beat_t;

  typedef struct packed {
    logic             emit;
    logic             border;
    logic             last;
    filt_mode_t       mode;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pixel;
  } tag_t;

endpackage

### hdl/bbls_line_ram.sv
// Line store memory holding the upper and middle rows, one entry per column.
module bbls_line_ram (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [bbls_pkg::COL_W-1:0]   rd_addr,
  output logic [bbls_pkg::LINE_W-1:0]  rd_data,
  input  logic                         wr_en,
  input  logic [bbls_pkg::COL_W-1:0]   wr_addr,
  input  logic [bbls_pkg::LINE_W-1:0]  wr_data
);

  logic [bbls_pkg::LINE_W-1:0] mem [bbls_pkg::MAX_WIDTH];
  logic [bbls_pkg::LINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/bbls_seq.sv
// Configuration registers and raster position tracking at the input beat.
module bbls_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [bbls_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbls_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_fire,
  input  bbls_pkg::in_beat_t               in_data,
  output logic                             tag_valid,
  output bbls_pkg::tag_t                   tag
);

  logic                          mode_r, mode_nxt;
  logic [bbls_pkg::WREG_W-1:0]   w_r, w_nxt;
  logic [bbls_pkg::HREG_W-1:0]   h_r, h_nxt;
  logic [bbls_pkg::COL_W-1:0]    in_col_r, in_col_nxt;
  logic [bbls_pkg::COL_W-1:0]    out_col_r, out_col_nxt;
  logic [bbls_pkg::ROW_W-1:0]    out_row_r, out_row_nxt;
  logic [bbls_pkg::WREG_W-1:0]   lead_r, lead_nxt;

  logic [bbls_pkg::WREG_W-1:0]   cfg_w;
  logic [bbls_pkg::HREG_W-1:0]   cfg_h;
  logic                          skip, emit, col_wrap, out_col_end, out_row_end, last;

  always_comb begin
    cfg_w = cfg_data[bbls_pkg::WREG_W-1:0];
    if (cfg_w < bbls_pkg::WREG_W'(3)) begin
      cfg_w = bbls_pkg::WREG_W'(3);
    end else if (cfg_w > bbls_pkg::WREG_W'(bbls_pkg::MAX_WIDTH)) begin
      cfg_w = bbls_pkg::WREG_W'(bbls_pkg::MAX_WIDTH);
    end
    cfg_h = cfg_data[bbls_pkg::HREG_W-1:0];
    if (cfg_h < bbls_pkg::HREG_W'(3)) begin
      cfg_h = bbls_pkg::HREG_W'(3);
    end else if (cfg_h > bbls_pkg::HREG_W'(bbls_pkg::MAX_HEIGHT)) begin
      cfg_h = bbls_pkg::HREG_W'(bbls_pkg::MAX_HEIGHT);
    end
  end

  always_comb begin
    skip        = in_data.drain && (lead_r == '0);
    emit        = (lead_r == (w_r + bbls_pkg::WREG_W'(1)));
    col_wrap    = ((bbls_pkg::WREG_W'(in_col_r) + bbls_pkg::WREG_W'(1)) >= w_r);
    out_col_end = (bbls_pkg::WREG_W'(out_col_r) == (w_r - bbls_pkg::WREG_W'(1)));
    out_row_end = (bbls_pkg::HREG_W'(out_row_r) == (h_r - bbls_pkg::HREG_W'(1)));
    last        = out_col_end && out_row_end;

    tag_valid   = in_fire && !skip;
    tag.emit    = emit;
    tag.border  = (out_row_r == '0) || out_row_end || (out_col_r == '0) || out_col_end;
    tag.last    = last;
    tag.mode    = bbls_pkg::filt_mode_t'(mode_r);
    tag.col     = in_col_r;
    tag.pixel   = in_data.drain ? '0 : in_data.pixel_in;
  end

  always_comb begin
    mode_nxt    = mode_r;
    w_nxt       = w_r;
    h_nxt       = h_r;
    in_col_nxt  = in_col_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    lead_nxt    = lead_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        bbls_pkg::CFG_MODE: begin
          mode_nxt = cfg_data[0];
        end
        bbls_pkg::CFG_WIDTH: begin
          w_nxt       = cfg_w;
          in_col_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
          lead_nxt    = '0;
        end
        bbls_pkg::CFG_HEIGHT: begin
          h_nxt       = cfg_h;
          in_col_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
          lead_nxt    = '0;
        end
        default: begin
        end
      endcase
    end else if (tag_valid) begin
      in_col_nxt = col_wrap ? '0 : in_col_r + bbls_pkg::COL_W'(1);
      if (!emit) begin
        lead_nxt = lead_r + bbls_pkg::WREG_W'(1);
      end else if (in_data.drain && last) begin
        in_col_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        lead_nxt    = '0;
      end else if (out_col_end) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_end ? '0 : out_row_r + bbls_pkg::ROW_W'(1);
      end else begin
        out_col_nxt = out_col_r + bbls_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= bbls_pkg::MODE_MEAN;
      w_r       <= bbls_pkg::WREG_W'(1024);
      h_r       <= bbls_pkg::HREG_W'(1024);
      in_col_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      lead_r    <= '0;
    end else begin
      mode_r    <= mode_nxt;
      w_r       <= w_nxt;
      h_r       <= h_nxt;
      in_col_r  <= in_col_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      lead_r    <= lead_nxt;
    end
  end

endmodule

### hdl/bbls_filter.sv
// Window update with line store write back, and the mean and sharpening arithmetic.
module bbls_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            tag_valid,
  input  bbls_pkg::tag_t                  tag,
  input  logic [bbls_pkg::LINE_W-1:0]     line_rd,
  output logic                            line_wr_en,
  output logic [bbls_pkg::COL_W-1:0]      line_wr_addr,
  output logic [bbls_pkg::LINE_W-1:0]     line_wr_data,
  output logic                            b_emit,
  output logic                            res_valid,
  output bbls_pkg::out_beat_t             res
);

  logic                        b_valid_r;
  bbls_pkg::tag_t              b_tag_r;
  logic [bbls_pkg::PIX_W-1:0]  win_r [6];

  logic                        c_valid_r;
  logic [bbls_pkg::RING_W-1:0] c_ring_r;
  logic [bbls_pkg::PIX_W-1:0]  c_centre_r;
  logic                        c_border_r;
  logic                        c_last_r;
  bbls_pkg::filt_mode_t        c_mode_r;

  logic [bbls_pkg::PIX_W-1:0]  top, mid;
  logic [bbls_pkg::RING_W-1:0] ring;

  logic [bbls_pkg::SUM_W-1:0]  total;
  logic [24:0]                 prod;
  logic signed [12:0]          lap;
  logic [bbls_pkg::PIX_W-1:0]  lap_c;
  logic [bbls_pkg::PIX_W:0]    diff;
  logic [bbls_pkg::PIX_W-1:0]  value;

  always_comb begin
    top  = line_rd[bbls_pkg::LINE_W-1:bbls_pkg::PIX_W];
    mid  = line_rd[bbls_pkg::PIX_W-1:0];
    ring = bbls_pkg::RING_W'(win_r[0]) + bbls_pkg::RING_W'(win_r[1])
         + bbls_pkg::RING_W'(win_r[2]) + bbls_pkg::RING_W'(win_r[3])
         + bbls_pkg::RING_W'(win_r[5]) + bbls_pkg::RING_W'(top)
         + bbls_pkg::RING_W'(mid)      + bbls_pkg::RING_W'(b_tag_r.pixel);
    line_wr_en   = b_valid_r;
    line_wr_addr = b_tag_r.col;
    line_wr_data = {mid, b_tag_r.pixel};
    b_emit       = b_valid_r && b_tag_r.emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      b_valid_r <= tag_valid;
      c_valid_r <= b_emit;
      if (b_valid_r) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= top;
        win_r[4] <= mid;
        win_r[5] <= b_tag_r.pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tag_valid) begin
      b_tag_r <= tag;
    end
    if (b_valid_r) begin
      c_ring_r   <= ring;
      c_centre_r <= win_r[4];
      c_border_r <= b_tag_r.border;
      c_last_r   <= b_tag_r.last;
      c_mode_r   <= b_tag_r.mode;
    end
  end

  always_comb begin
    total = bbls_pkg::SUM_W'(c_ring_r) + bbls_pkg::SUM_W'(c_centre_r);
    prod  = 25'(total) * 25'(bbls_pkg::MEAN_RECIP);
    lap   = $signed({2'b00, c_ring_r}) - $signed({2'b00, c_centre_r, 3'b000});
    if (lap[12]) begin
      lap_c = '0;
    end else if (lap > 13'sd255) begin
      lap_c = bbls_pkg::PIX_MAX;
    end else begin
      lap_c = lap[bbls_pkg::PIX_W-1:0];
    end
    diff = {1'b0, c_centre_r} - {1'b0, lap_c};
    unique case (c_mode_r)
      bbls_pkg::MODE_MEAN: begin
        value = c_border_r ? bbls_pkg::PIX_MAX
                           : prod[bbls_pkg::MEAN_SHIFT +: bbls_pkg::PIX_W];
      end
      bbls_pkg::MODE_SHARPEN: begin
        if (c_border_r) begin
          value = c_centre_r;
        end else begin
          value = diff[bbls_pkg::PIX_W] ? '0 : diff[bbls_pkg::PIX_W-1:0];
        end
      end
      default: begin
        value = '0;
      end
    endcase
    res_valid      = c_valid_r;
    res.pixel_out  = value;
    res.frame_last = c_last_r;
  end

endmodule

### hdl/bbls_out_fifo.sv
// Output queue that decouples the result channel from the pixel pipeline.
module bbls_out_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  bbls_pkg::out_beat_t            push_data,
  input  logic                           pop,
  output logic                           not_empty,
  output bbls_pkg::out_beat_t            head,
  output logic [bbls_pkg::FIFO_CW-1:0]   count
);

  bbls_pkg::out_beat_t                mem [bbls_pkg::FIFO_DEPTH];
  logic [bbls_pkg::FIFO_AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [bbls_pkg::FIFO_AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [bbls_pkg::FIFO_CW-1:0]       count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + bbls_pkg::FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + bbls_pkg::FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + bbls_pkg::FIFO_CW'(push) - bbls_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];
  assign count     = count_r;

endmodule

### hdl/box_blur_laplacian_sharpen_3x3_unit.sv
// 3x3 mean blur and Laplacian sharpening unit on an 8-bit raster pixel stream.
// Throughput is one input beat per cycle while in_ready is high, limited by the single line
// store read per beat. A result passes stages B and C and the output queue after the beat
// completing its window, image_width+1 beats after its pixel; drains flush the frame tail.
// Synchronous active-low reset clears positions, window and queue and sets mode 0,
// width 1024 and height 1024; line store contents are undefined until written.
module box_blur_laplacian_sharpen_3x3_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bbls_pkg::in_beat_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bbls_pkg::out_beat_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bbls_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbls_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                             in_fire;
  logic                             tag_valid;
  bbls_pkg::tag_t                   tag;
  logic [bbls_pkg::LINE_W-1:0]      line_rd;
  logic                             line_wr_en;
  logic [bbls_pkg::COL_W-1:0]       line_wr_addr;
  logic [bbls_pkg::LINE_W-1:0]      line_wr_data;
  logic                             b_emit;
  logic                             res_valid;
  bbls_pkg::out_beat_t              res;
  logic [bbls_pkg::FIFO_CW-1:0]     fifo_count;
  logic [bbls_pkg::FIFO_CW:0]       owed;

  assign owed      = (bbls_pkg::FIFO_CW+1)'(fifo_count) + (bbls_pkg::FIFO_CW+1)'(b_emit)
                   + (bbls_pkg::FIFO_CW+1)'(res_valid);
  assign in_ready  = (owed < (bbls_pkg::FIFO_CW+1)'(bbls_pkg::FIFO_DEPTH));
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  bbls_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .tag_valid (tag_valid),
    .tag       (tag)
  );

  bbls_line_ram u_line_ram (
    .clk     (clk),
    .rd_en   (tag_valid),
    .rd_addr (tag.col),
    .rd_data (line_rd),
    .wr_en   (line_wr_en),
    .wr_addr (line_wr_addr),
    .wr_data (line_wr_data)
  );

  bbls_filter u_filter (
    .clk          (clk),
    .rst_n        (rst_n),
    .tag_valid    (tag_valid),
    .tag          (tag),
    .line_rd      (line_rd),
    .line_wr_en   (line_wr_en),
    .line_wr_addr (line_wr_addr),
    .line_wr_data (line_wr_data),
    .b_emit       (b_emit),
    .res_valid    (res_valid),
    .res          (res)
  );

  bbls_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (out_valid && out_ready),
    .not_empty (out_valid),
    .head      (out_data),
    .count     (fifo_count)
  );

endmodule

### bench/bbls_result_checker.sv
`timescale 1ns / 100ps
// Checker that predicts and compares every output beat of the 3x3 blur and sharpen unit.
module bbls_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  bbls_pkg::in_beat_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  bbls_pkg::out_beat_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [bbls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbls_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              owed_count
);

  logic [bbls_pkg::PIX_W-1:0]  upper_line [bbls_pkg::MAX_WIDTH];
  logic [bbls_pkg::PIX_W-1:0]  middle_line [bbls_pkg::MAX_WIDTH];
  logic [bbls_pkg::PIX_W-1:0]  win_cells [6];
  int unsigned                 in_col, in_row, out_col, out_row;
  bbls_pkg::filt_mode_t        mode_q;
  logic [bbls_pkg::WREG_W-1:0] width_q;
  logic [bbls_pkg::HREG_W-1:0] height_q;
  bbls_pkg::out_beat_t         owed_pixels [$];
  bbls_pkg::out_beat_t         want_beat;
  int                          mismatches = 0;
  int                          owed = 0;

  assign fail_count = mismatches;
  assign owed_count = owed;

  function automatic int unsigned fit(input int unsigned v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic restart_pos();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endtask

  task automatic advance(inout int unsigned col, inout int unsigned row,
                         input int unsigned w, input int unsigned h);
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
  endtask

  task automatic filter_step(input bbls_pkg::in_beat_t b);
    int unsigned w, h, frame, n, m, lead, c, ring;
    int lap, v;
    logic [bbls_pkg::PIX_W-1:0] p, top_px, mid_px, centre;
    logic emit, border;
    bbls_pkg::out_beat_t res;
    w = fit(width_q, bbls_pkg::MAX_WIDTH);
    h = fit(height_q, bbls_pkg::MAX_HEIGHT);
    frame = w * h;
    p = b.drain ? '0 : b.pixel_in;
    n = (in_row * w + in_col) % frame;
    m = (out_row * w + out_col) % frame;
    lead = (n + frame - m) % frame;
    c = in_col % bbls_pkg::MAX_WIDTH;
    top_px = upper_line[c];
    mid_px = middle_line[c];
    emit = (lead == w + 1);
    res = '0;
    if (b.drain && lead == 0) return;
    if (emit) begin
      centre = win_cells[4];
      ring = win_cells[0] + win_cells[1] + win_cells[2] + win_cells[3] + win_cells[5]
           + top_px + mid_px + p;
      border = (out_row == 0 || out_row >= h - 1 || out_col == 0 || out_col >= w - 1);
      if (mode_q == bbls_pkg::MODE_MEAN) begin
        res.pixel_out = border ? bbls_pkg::PIX_MAX : 8'((ring + centre) / 9);
      end else if (border) begin
        res.pixel_out = centre;
      end else begin
        lap = int'(ring) - 8 * int'(centre);
        if (lap < 0) lap = 0;
        if (lap > 255) lap = 255;
        v = int'(centre) - lap;
        res.pixel_out = (v < 0) ? '0 : 8'(v);
      end
      res.frame_last = (out_row == h - 1 && out_col == w - 1);
    end
    win_cells[0] = win_cells[3];
    win_cells[1] = win_cells[4];
    win_cells[2] = win_cells[5];
    win_cells[3] = top_px;
    win_cells[4] = mid_px;
    win_cells[5] = p;
    upper_line[c] = mid_px;
    middle_line[c] = p;
    advance(in_col, in_row, w, h);
    if (emit) begin
      advance(out_col, out_row, w, h);
      if (b.drain && res.frame_last) restart_pos();
      owed_pixels.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bbls_pkg::MAX_WIDTH; i++) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      for (int i = 0; i < 6; i++) win_cells[i] = '0;
      restart_pos();
      mode_q = bbls_pkg::MODE_MEAN;
      width_q = bbls_pkg::WREG_W'(1024);
      height_q = bbls_pkg::HREG_W'(1024);
      owed_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bbls_pkg::CFG_MODE: mode_q = bbls_pkg::filt_mode_t'(cfg_data[0]);
          bbls_pkg::CFG_WIDTH: begin
            width_q = cfg_data[bbls_pkg::WREG_W-1:0];
            restart_pos();
          end
          bbls_pkg::CFG_HEIGHT: begin
            height_q = cfg_data[bbls_pkg::HREG_W-1:0];
            restart_pos();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) filter_step(in_data);
      if (out_valid && out_ready) begin
        if (owed_pixels.size() == 0) begin
          report($sformatf("output beat with pixel_out %0d and nothing expected",
                           out_data.pixel_out));
        end else begin
          want_beat = owed_pixels.pop_front();
          if (out_data.pixel_out !== want_beat.pixel_out)
            report($sformatf("pixel_out got %0d expected %0d",
                             out_data.pixel_out, want_beat.pixel_out));
          if (out_data.frame_last !== want_beat.frame_last)
            report($sformatf("frame_last got %0b expected %0b",
                             out_data.frame_last, want_beat.frame_last));
        end
      end
    end
    owed = owed_pixels.size();
  end

endmodule

### bench/box_blur_laplacian_sharpen_3x3_unit_tb.sv
`timescale 1ns / 100ps
// Top of the testbench: clock, reset, stimulus and verdict for the 3x3 blur and sharpen unit.
module box_blur_laplacian_sharpen_3x3_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_SLACK = 12;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned WIDE_ROW    = 64;
  localparam logic [bbls_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  // Raster order with the first pixel in the lowest byte.
  localparam logic [8*9-1:0] CORNER_FRAME = {8'd0, 8'd255, 8'd255, 8'd255, 8'd0,
                                             8'd255, 8'd255, 8'd0, 8'd255};

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  bbls_pkg::in_beat_t              in_data;
  logic                            out_valid;
  logic                            out_ready;
  bbls_pkg::out_beat_t             out_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [bbls_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bbls_pkg::CFG_DATA_W-1:0] cfg_data;
  int unsigned                     send_idle_pct;
  int unsigned                     recv_idle_pct;
  logic                            hold_req;
  int                              fail_count;
  int                              owed_count;
  int unsigned                     cycle_count;

  box_blur_laplacian_sharpen_3x3_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bbls_result_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .owed_count (owed_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // A rising hold request makes the sink refuse beats for a long stretch.
  initial begin : sink_proc
    int unsigned hold_left;
    logic        hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_seen) hold_left = HOLD_CYCLES;
      hold_seen = hold_req;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [bbls_pkg::PIX_W-1:0] pick_pixel();
    case ($urandom_range(9))
      0: return '0;
      1: return bbls_pkg::PIX_MAX;
      default: return bbls_pkg::PIX_W'($urandom_range(255));
    endcase
  endfunction

  function automatic int unsigned dim_in_use(input int unsigned v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic send_beat(input logic [bbls_pkg::PIX_W-1:0] px, input logic drn);
    bbls_pkg::in_beat_t b;
    b.pixel_in = px;
    b.drain = drn;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (owed_count != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bbls_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bbls_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(input bbls_pkg::filt_mode_t md,
                           input logic [bbls_pkg::CFG_DATA_W-1:0] wdata,
                           input logic [bbls_pkg::CFG_DATA_W-1:0] hdata);
    settle();
    write_reg(bbls_pkg::CFG_MODE, bbls_pkg::CFG_DATA_W'(md));
    write_reg(bbls_pkg::CFG_WIDTH, wdata);
    write_reg(bbls_pkg::CFG_HEIGHT, hdata);
    cfg_valid <= 1'b0;
  endtask

  // Random-content frames, cut off at the pixel budget, with a few stray drains and flushes now and then.
  // A wide frame ends without a flush to keep the run short.
  task automatic run_frames(input int unsigned budget, input int unsigned w,
                            input int unsigned h, input logic squeeze);
    int unsigned sent, pos;
    sent = 0;
    pos = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 4) begin
        send_beat(pick_pixel(), 1'b1);
      end else begin
        send_beat(pick_pixel(), 1'b0);
        sent++;
        if (squeeze && sent == 20) hold_req <= 1'b1;
      end
      pos++;
      if (pos == w * h) begin
        pos = 0;
        if ($urandom_range(1)) repeat (w + 2) send_beat(pick_pixel(), 1'b1);
      end
    end
    if (w < WIDE_ROW && $urandom_range(1)) repeat (w + 2) send_beat(pick_pixel(), 1'b1);
  endtask

  task automatic run_segment(input bbls_pkg::filt_mode_t md,
                             input logic [bbls_pkg::CFG_DATA_W-1:0] wdata,
                             input logic [bbls_pkg::CFG_DATA_W-1:0] hdata,
                             input int unsigned budget, input logic squeeze);
    configure(md, wdata, hdata);
    run_frames(budget, dim_in_use(wdata[bbls_pkg::WREG_W-1:0], bbls_pkg::MAX_WIDTH),
               dim_in_use(hdata[bbls_pkg::HREG_W-1:0], bbls_pkg::MAX_HEIGHT), squeeze);
  endtask

  task automatic random_segment();
    logic [bbls_pkg::CFG_DATA_W-1:0] wd, hd;
    case ($urandom_range(7))
      0: wd = bbls_pkg::CFG_DATA_W'($urandom_range(2));
      1: wd = bbls_pkg::CFG_DATA_W'($urandom_range(40, 13));
      default: wd = bbls_pkg::CFG_DATA_W'($urandom_range(12, 3));
    endcase
    wd[bbls_pkg::CFG_DATA_W-1:bbls_pkg::WREG_W] = 2'($urandom_range(3));
    if ($urandom_range(7) == 0) hd = bbls_pkg::CFG_DATA_W'($urandom_range(2));
    else hd = bbls_pkg::CFG_DATA_W'($urandom_range(8, 3));
    run_segment(bbls_pkg::filt_mode_t'($urandom_range(1)), wd, hd,
                $urandom_range(80, 30), 1'b0);
  endtask

  initial begin : stimulus
    int phase, seg;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = bbls_pkg::CFG_MODE;
    cfg_data = '0;
    hold_req = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 45;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Undersized 3x3 frame in sharpen mode: an idle drain, both clamps, a partial flush,
    // then a mode change while results are owed and a flush that ends the frame.
    configure(bbls_pkg::MODE_SHARPEN, bbls_pkg::CFG_DATA_W'(2), bbls_pkg::CFG_DATA_W'(0));
    send_beat(bbls_pkg::PIX_MAX, 1'b1);
    for (int i = 0; i < 9; i++) send_beat(CORNER_FRAME[8*i +: 8], 1'b0);
    repeat (2) send_beat(pick_pixel(), 1'b1);
    repeat (2) send_beat('0, 1'b0);
    settle();
    write_reg(bbls_pkg::CFG_MODE, bbls_pkg::CFG_DATA_W'(bbls_pkg::MODE_MEAN));
    write_reg(CFG_SPARE, '1);
    cfg_valid <= 1'b0;
    send_beat(bbls_pkg::PIX_MAX, 1'b0);
    repeat (4) send_beat('0, 1'b0);
    repeat (4) send_beat(pick_pixel(), 1'b1);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct <= 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct <= 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (seg = 0; seg < 3; seg++) begin
        if (phase < 2 && seg == 2)
          run_segment(bbls_pkg::filt_mode_t'($urandom_range(1)), bbls_pkg::CFG_DATA_W'(5),
                      bbls_pkg::CFG_DATA_W'(6), 80, 1'b1);
        else
          random_segment();
      end
      hold_req <= 1'b0;
    end
    run_segment(bbls_pkg::filt_mode_t'($urandom_range(1)), '1, bbls_pkg::CFG_DATA_W'(3),
                1040, 1'b0);
    run_segment(bbls_pkg::MODE_SHARPEN, bbls_pkg::CFG_DATA_W'(3), '1, 60, 1'b0);
    settle();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/bbls_pkg.sv
hdl/bbls_line_ram.sv
hdl/bbls_seq.sv
hdl/bbls_filter.sv
hdl/bbls_out_fifo.sv
hdl/box_blur_laplacian_sharpen_3x3_unit.sv
bench/bbls_result_checker.sv
bench/box_blur_laplacian_sharpen_3x3_unit_tb.sv
